FILE: rtl/sexpr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character helpers for the s-expression token lexer.
package sexpr_pkg;

    // Output queue depth; must be at least 2 so a two-result item always fits.
    localparam int OUTQ_DEPTH = 4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_ATOM
    } lex_mode_t;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_ZERO,
        PH_BODY,
        PH_FAIL
    } num_phase_t;

    // Result kinds
    localparam logic [3:0] KIND_OPEN   = 4'd0;
    localparam logic [3:0] KIND_CLOSE  = 4'd1;
    localparam logic [3:0] KIND_QUOTE  = 4'd2;
    localparam logic [3:0] KIND_SCHAR  = 4'd3;
    localparam logic [3:0] KIND_SEND   = 4'd4;
    localparam logic [3:0] KIND_ACHAR  = 4'd5;
    localparam logic [3:0] KIND_NUMBER = 4'd6;
    localparam logic [3:0] KIND_SYMBOL = 4'd7;
    localparam logic [3:0] KIND_END    = 4'd8;

    // Characters with special meaning
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [5:0] RADIX_DEFAULT = 6'd10;
    localparam logic [5:0] NOT_A_DIGIT   = 6'd36;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         char_out;
        logic signed [63:0] number_value;
        logic               last_of_run;
    } out_item_t;

    typedef struct packed {
        lex_mode_t   mode;
        num_phase_t  phase;
        logic        negate;
        logic [5:0]  radix;
        logic [63:0] acc;
        logic        seen;
    } lex_state_t;

    // Results of one item, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_res_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
    endfunction

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (l >= CH_ZERO && l <= CH_NINE)
            return 6'(l - CH_ZERO);
        else if (l >= CH_LOWER_A && l <= CH_LOWER_Z)
            return 6'(l - CH_LOWER_A + 8'd10);
        else
            return NOT_A_DIGIT;
    endfunction

    // Base picked by the letter after a leading zero; zero when none matches.
    function automatic logic [5:0] prefix_radix(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        case (l)
            8'h62:   return 6'd2;   // b
            8'h73:   return 6'd6;   // s
            8'h6F:   return 6'd8;   // o
            8'h64:   return 6'd10;  // d
            8'h7A:   return 6'd12;  // z
            8'h78:   return 6'd16;  // x
            8'h6E:   return 6'd36;  // n
            default: return 6'd0;
        endcase
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_HASH ||
               c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN ||
               c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction

    function automatic out_item_t make_item(input logic [3:0] kind,
                                            input logic [7:0] ch,
                                            input logic [63:0] val);
        out_item_t r;
        r.kind         = kind;
        r.char_out     = ch;
        r.number_value = val;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

FILE: rtl/sexpr_token_lexer_core.sv
`timescale 1ns / 1ps
// Top level of the s-expression token lexer: input stage, lexer state, result queue.
//
// The lexer takes one source byte (or an end mark) per transfer on the byte
// channel and returns tokens on the tok channel: open, close and quote
// tokens, string characters and string end, atom characters followed by a
// number or symbol verdict, and an end token. Each byte is held in an input
// register; once the queue has room, one pass of mode logic and a 64-bit by
// 6-bit multiply-add updates the lexer state and pushes zero, one or two results
// into a four-entry result queue, which drives the tok channel from its head.
// A byte is taken every cycle as long as the queue has room for two results,
// so the sustained rate is one byte per cycle; the tok channel returns one
// result per cycle while tok_ready is high, so bytes that cause two results (an
// atom ended by a token or end mark, end inside a string) set the pace when they
// cluster.
// The last result caused by a byte carries last_of_run.
module sexpr_token_lexer_core #(
    parameter int OUTQ_DEPTH = sexpr_pkg::OUTQ_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  sexpr_pkg::in_item_t  byte_item,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output sexpr_pkg::out_item_t tok_item
);

    sexpr_pkg::in_item_t   item_reg;
    logic                  item_valid_reg;
    sexpr_pkg::lex_state_t state_reg;
    sexpr_pkg::lex_state_t state_next;
    sexpr_pkg::step_res_t  step_res;
    sexpr_pkg::step_res_t  push;
    logic                  room;
    logic                  go;

    // Process the held byte only when both of its possible results fit
    assign go         = item_valid_reg && room;
    assign byte_ready = !item_valid_reg || go;

    always_comb
    begin
        push = step_res;
        if (!go)
            push.count = 2'd0;
    end

    // Input register: payload needs no reset
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            item_reg <= byte_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            state_reg.mode   <= sexpr_pkg::MODE_IDLE;
            state_reg.phase  <= sexpr_pkg::PH_SIGN;
            state_reg.negate <= 1'b0;
            state_reg.radix  <= sexpr_pkg::RADIX_DEFAULT;
            state_reg.acc    <= 64'd0;
            state_reg.seen   <= 1'b0;
        end
        else
        begin
            // hold the byte until it is processed, then load the next one
            if (byte_valid && byte_ready)
                item_valid_reg <= 1'b1;
            else if (go)
                item_valid_reg <= 1'b0;
            // advance the lexer state once per processed byte
            if (go)
                state_reg <= state_next;
        end
    end

    sexpr_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .res        (step_res)
    );

    sexpr_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    a_hold_unprocessed: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !go |=> item_valid_reg && $stable(item_reg))
        else $error("held byte lost before processing");

    a_end_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go && item_reg.is_end |=> state_reg.mode == sexpr_pkg::MODE_IDLE)
        else $error("lexer not between tokens after end mark");

    a_pair_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
        else $error("last_of_run misplaced on a result pair");

endmodule

FILE: rtl/sexpr_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one lexer item.
module sexpr_step (
    input  sexpr_pkg::lex_state_t state,
    input  sexpr_pkg::in_item_t   item,
    output sexpr_pkg::lex_state_t state_next,
    output sexpr_pkg::step_res_t  res
);

    logic [7:0]            c;
    logic                  e;
    sexpr_pkg::lex_state_t base;
    sexpr_pkg::lex_state_t fed;
    logic [5:0]            digit;
    logic [5:0]            pfx;
    logic [69:0]           prod;
    logic [63:0]           acc_take;
    logic                  digit_bad;

    logic                  idle_has;
    sexpr_pkg::out_item_t  idle_item;
    sexpr_pkg::lex_mode_t  idle_mode;
    logic                  idle_start;

    logic                  a_has;
    logic                  b_has;
    sexpr_pkg::out_item_t  a_item;
    sexpr_pkg::out_item_t  b_item;
    sexpr_pkg::out_item_t  verdict_item;
    logic                  in_atom_feed;

    assign c = item.char_in;
    assign e = item.is_end;

    // Between-token handling of the current byte or end mark
    always_comb
    begin
        idle_has   = 1'b0;
        idle_item  = sexpr_pkg::make_item(sexpr_pkg::KIND_END, 8'd0, 64'd0);
        idle_mode  = sexpr_pkg::MODE_IDLE;
        idle_start = 1'b0;
        if (e)
        begin
            idle_has = 1'b1;
        end
        else
        begin
            case (c)
                sexpr_pkg::CH_SPACE, sexpr_pkg::CH_TAB, sexpr_pkg::CH_NL:
                begin
                end
                sexpr_pkg::CH_HASH, sexpr_pkg::CH_SEMI:
                    idle_mode = sexpr_pkg::MODE_COMMENT;
                sexpr_pkg::CH_LPAREN:
                begin
                    idle_has  = 1'b1;
                    idle_item = sexpr_pkg::make_item(sexpr_pkg::KIND_OPEN, 8'd0, 64'd0);
                end
                sexpr_pkg::CH_RPAREN:
                begin
                    idle_has  = 1'b1;
                    idle_item = sexpr_pkg::make_item(sexpr_pkg::KIND_CLOSE, 8'd0, 64'd0);
                end
                sexpr_pkg::CH_SQUOTE:
                begin
                    idle_has  = 1'b1;
                    idle_item = sexpr_pkg::make_item(sexpr_pkg::KIND_QUOTE, 8'd0, 64'd0);
                end
                sexpr_pkg::CH_DQUOTE:
                    idle_mode = sexpr_pkg::MODE_STRING;
                default:
                begin
                    idle_has   = 1'b1;
                    idle_item  = sexpr_pkg::make_item(sexpr_pkg::KIND_ACHAR, c, 64'd0);
                    idle_mode  = sexpr_pkg::MODE_ATOM;
                    idle_start = 1'b1;
                end
            endcase
        end
    end

    // Number recognizer: a fresh atom starts from the reset number state
    always_comb
    begin
        base = state;
        if (!(state.mode == sexpr_pkg::MODE_ATOM))
        begin
            base.phase  = sexpr_pkg::PH_SIGN;
            base.negate = 1'b0;
            base.radix  = sexpr_pkg::RADIX_DEFAULT;
            base.acc    = 64'd0;
            base.seen   = 1'b0;
        end
    end

    assign digit     = sexpr_pkg::digit_of(c);
    assign pfx       = sexpr_pkg::prefix_radix(c);
    assign digit_bad = digit >= base.radix;
    assign prod      = base.acc * base.radix;
    assign acc_take  = prod[63:0] + 64'(digit);

    always_comb
    begin
        fed = base;
        case (base.phase)
            sexpr_pkg::PH_SIGN:
            begin
                if (c == sexpr_pkg::CH_PLUS)
                begin
                end
                else if (c == sexpr_pkg::CH_MINUS)
                    fed.negate = ~base.negate;
                else if (c == sexpr_pkg::CH_ZERO)
                begin
                    fed.phase = sexpr_pkg::PH_ZERO;
                    fed.acc   = 64'd0;
                    fed.seen  = 1'b1;
                end
                else if (digit_bad)
                    fed.phase = sexpr_pkg::PH_FAIL;
                else
                begin
                    fed.phase = sexpr_pkg::PH_BODY;
                    fed.acc   = acc_take;
                    fed.seen  = 1'b1;
                end
            end
            sexpr_pkg::PH_ZERO:
            begin
                if (pfx != 6'd0)
                begin
                    fed.radix = pfx;
                    fed.acc   = 64'd0;
                    fed.seen  = 1'b0;
                    fed.phase = sexpr_pkg::PH_BODY;
                end
                else if (digit_bad)
                    fed.phase = sexpr_pkg::PH_FAIL;
                else
                begin
                    fed.phase = sexpr_pkg::PH_BODY;
                    fed.acc   = acc_take;
                    fed.seen  = 1'b1;
                end
            end
            sexpr_pkg::PH_BODY:
            begin
                if (digit_bad)
                    fed.phase = sexpr_pkg::PH_FAIL;
                else
                begin
                    fed.acc  = acc_take;
                    fed.seen = 1'b1;
                end
            end
            default:
                fed.phase = sexpr_pkg::PH_FAIL;
        endcase
    end

    // Atom verdict from the number state held so far
    always_comb
    begin
        if (state.phase == sexpr_pkg::PH_FAIL || !state.seen)
            verdict_item = sexpr_pkg::make_item(sexpr_pkg::KIND_SYMBOL, 8'd0, 64'd0);
        else
            verdict_item = sexpr_pkg::make_item(sexpr_pkg::KIND_NUMBER, 8'd0,
                state.negate ? (64'd0 - state.acc) : state.acc);
    end

    // Mode dispatch
    always_comb
    begin
        state_next   = state;
        a_has        = 1'b0;
        b_has        = 1'b0;
        a_item       = sexpr_pkg::make_item(sexpr_pkg::KIND_END, 8'd0, 64'd0);
        b_item       = sexpr_pkg::make_item(sexpr_pkg::KIND_END, 8'd0, 64'd0);
        in_atom_feed = 1'b0;
        case (state.mode)
            sexpr_pkg::MODE_COMMENT:
            begin
                if (e)
                begin
                    state_next.mode = sexpr_pkg::MODE_IDLE;
                    a_has           = 1'b1;
                end
                else if (c == sexpr_pkg::CH_NL)
                    state_next.mode = sexpr_pkg::MODE_IDLE;
            end
            sexpr_pkg::MODE_STRING, sexpr_pkg::MODE_ESCAPE:
            begin
                if (e)
                begin
                    state_next.mode = sexpr_pkg::MODE_IDLE;
                    a_has           = 1'b1;
                    a_item = sexpr_pkg::make_item(sexpr_pkg::KIND_SEND, 8'd0, 64'd0);
                    b_has           = 1'b1;
                end
                else if (state.mode == sexpr_pkg::MODE_ESCAPE)
                begin
                    state_next.mode = sexpr_pkg::MODE_STRING;
                    a_has           = 1'b1;
                    a_item = sexpr_pkg::make_item(sexpr_pkg::KIND_SCHAR, c, 64'd0);
                end
                else if (c == sexpr_pkg::CH_BSLASH)
                    state_next.mode = sexpr_pkg::MODE_ESCAPE;
                else if (c == sexpr_pkg::CH_DQUOTE)
                begin
                    state_next.mode = sexpr_pkg::MODE_IDLE;
                    a_has           = 1'b1;
                    a_item = sexpr_pkg::make_item(sexpr_pkg::KIND_SEND, 8'd0, 64'd0);
                end
                else
                begin
                    a_has  = 1'b1;
                    a_item = sexpr_pkg::make_item(sexpr_pkg::KIND_SCHAR, c, 64'd0);
                end
            end
            sexpr_pkg::MODE_ATOM:
            begin
                if (e || sexpr_pkg::is_term(c))
                begin
                    // verdict first, then the terminator as between tokens
                    a_has           = 1'b1;
                    a_item          = verdict_item;
                    b_has           = idle_has;
                    b_item          = idle_item;
                    state_next.mode = idle_mode;
                end
                else
                begin
                    in_atom_feed = 1'b1;
                    a_has        = 1'b1;
                    a_item = sexpr_pkg::make_item(sexpr_pkg::KIND_ACHAR, c, 64'd0);
                end
            end
            default:
            begin
                state_next.mode = idle_mode;
                a_has           = idle_has;
                a_item          = idle_item;
                in_atom_feed    = idle_start;
            end
        endcase
        if (in_atom_feed)
        begin
            state_next.phase  = fed.phase;
            state_next.negate = fed.negate;
            state_next.radix  = fed.radix;
            state_next.acc    = fed.acc;
            state_next.seen   = fed.seen;
        end
        a_item.last_of_run = ~b_has;
        b_item.last_of_run = 1'b1;
        res.count  = {1'b0, a_has} + {1'b0, b_has};
        res.first  = a_item;
        res.second = b_item;
    end

endmodule

FILE: rtl/sexpr_outq.sv
`timescale 1ns / 1ps
// Small result queue that takes up to two results a cycle and returns one while tok_ready is high.
module sexpr_outq #(
    parameter int DEPTH = sexpr_pkg::OUTQ_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sexpr_pkg::step_res_t push,
    output logic                 room,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output sexpr_pkg::out_item_t tok_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sexpr_pkg::out_item_t entries [DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_reg;
    logic [CW-1:0]        count_reg;
    logic [PW-1:0]        wr1;
    logic [PW-1:0]        wr2;
    logic                 pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr1       = ptr_inc(wr_ptr_reg);
    assign wr2       = ptr_inc(wr1);
    assign pop       = tok_valid && tok_ready;
    assign tok_valid = count_reg != '0;
    assign tok_item  = entries[rd_ptr_reg];
    assign room      = count_reg <= CW'(DEPTH - 2);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entries[wr1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.count == 2'd1)
                wr_ptr_reg <= wr1;
            else if (push.count == 2'd2)
                wr_ptr_reg <= wr2;
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_reg + CW'(push.count) - CW'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count past depth");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= CW'(DEPTH) - CW'(push.count))
        else $error("result queue overflow");

endmodule
